@@ sv/bmi_pkg.sv @@
// shared types and constants for the binary modular inverse block
// no dependencies; imported by bmi_core and binary_modular_inverse

package bmi_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REDUCE,
		ST_SETUP,
		ST_TEST,
		ST_HALVE_U,
		ST_HALVE_V,
		ST_CMP,
		ST_PICK,
		ST_FIX,
		ST_DONE
	} bmi_state_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_ZERO  = 2'd1;
	localparam logic [1:0] STATUS_NOINV = 2'd2;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [1:0] status;
	} bmi_ctl_t;

endpackage

@@ sv/bmi_core.sv @@
// iterative inversion engine: one reduce step per cycle
// depends on bmi_pkg

module bmi_core import bmi_pkg::*; #(
	parameter int WORDS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [32*WORDS-1:0] value_in,
	input  logic [32*WORDS-1:0] modulus_in,
	output bmi_ctl_t            ctl,
	output logic [32*WORDS-1:0] result
);

	localparam int W  = 32 * WORDS;
	localparam int C  = W + 32;
	localparam int BW = $clog2(C);

	bmi_state_t state_q, state_n;

	logic [W-1:0]  u_q, u_n, v_q, v_n, m_q, m_n, a1_q, a1_n, rem_q, rem_n, res_q, res_n;
	logic [C-1:0]  a_q, a_n, b_q, b_n, c_q, c_n, d_q, d_n, dd_q, dd_n;
	logic [BW-1:0] bcnt_q, bcnt_n;
	logic          odd_q, odd_n, neg_q, neg_n, second_q, second_n;
	logic [1:0]    status_q, status_n;

	logic [C-1:0] m_ext, a1_ext, p_sum, q_dif;
	logic [W:0]   rstep;
	logic [W+1:0] rdiff;
	logic         u_one, v_one, last_bit;

	assign m_ext  = C'(m_q);
	assign a1_ext = C'(a1_q);
	assign u_one  = (u_q == W'(1));
	assign v_one  = (v_q == W'(1));
	assign rstep  = {rem_q, dd_q[C-1]};
	assign rdiff  = {1'b0, rstep} - {2'b00, m_q};
	assign last_bit = (bcnt_q == BW'(C - 1));

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_n = ST_CHECK;
			ST_CHECK:   state_n = (dd_q == '0 || m_q == '0) ? ST_DONE : ST_REDUCE;
			ST_REDUCE:  if (last_bit) state_n = second_q ? ST_FIX : ST_SETUP;
			ST_SETUP: begin
				if ((rem_q == '0 && m_q != W'(1)) || (!m_q[0] && !rem_q[0]))
					state_n = ST_DONE;
				else
					state_n = ST_TEST;
			end
			ST_TEST:    state_n = (u_one || v_one) ? ST_PICK : ST_HALVE_U;
			ST_HALVE_U: if (u_q[0]) state_n = ST_HALVE_V;
			ST_HALVE_V: if (v_q[0]) state_n = ST_CMP;
			ST_CMP:     state_n = (u_q == v_q) ? ST_PICK : ST_TEST;
			ST_PICK:    state_n = (u_one || v_one) ? ST_REDUCE : ST_DONE;
			ST_FIX:     state_n = ST_DONE;
			ST_DONE:    state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	// datapath
	always_comb begin
		u_n = u_q; v_n = v_q; m_n = m_q; a1_n = a1_q; rem_n = rem_q; res_n = res_q;
		a_n = a_q; b_n = b_q; c_n = c_q; d_n = d_q; dd_n = dd_q;
		bcnt_n = bcnt_q; odd_n = odd_q; neg_n = neg_q; second_n = second_q;
		status_n = status_q;
		p_sum = '0;
		q_dif = '0;
		case (state_q)
			ST_IDLE: begin
				dd_n     = C'(value_in);
				m_n      = modulus_in;
				rem_n    = '0;
				bcnt_n   = '0;
				second_n = 1'b0;
			end
			ST_CHECK: begin
				if (dd_q == '0 || m_q == '0) begin
					status_n = STATUS_ZERO;
					res_n    = '0;
				end
			end
			ST_REDUCE: begin
				// restoring step: shift in next dividend bit, subtract when it fits
				rem_n  = rdiff[W+1] ? rstep[W-1:0] : rdiff[W-1:0];
				dd_n   = {dd_q[C-2:0], 1'b0};
				bcnt_n = bcnt_q + BW'(1);
			end
			ST_SETUP: begin
				a1_n  = rem_q;
				u_n   = rem_q;
				v_n   = m_q;
				odd_n = m_q[0];
				a_n   = C'(1);
				b_n   = '0;
				c_n   = '0;
				d_n   = m_q[0] ? '0 : C'(1);
				if ((rem_q == '0 && m_q != W'(1)) || (!m_q[0] && !rem_q[0])) begin
					status_n = STATUS_NOINV;
					res_n    = '0;
				end
			end
			ST_HALVE_U: begin
				if (!u_q[0]) begin
					u_n = u_q >> 1;
					if (odd_q) begin
						p_sum = a_q[0] ? a_q + m_ext : a_q;
						a_n   = p_sum >> 1;
					end else begin
						p_sum = (a_q[0] | b_q[0]) ? a_q + m_ext : a_q;
						q_dif = (a_q[0] | b_q[0]) ? b_q - a1_ext : b_q;
						a_n   = {p_sum[C-1], p_sum[C-1:1]};
						b_n   = {q_dif[C-1], q_dif[C-1:1]};
					end
				end
			end
			ST_HALVE_V: begin
				if (!v_q[0]) begin
					v_n = v_q >> 1;
					if (odd_q) begin
						p_sum = c_q[0] ? c_q + m_ext : c_q;
						c_n   = p_sum >> 1;
					end else begin
						p_sum = (c_q[0] | d_q[0]) ? c_q + m_ext : c_q;
						q_dif = (c_q[0] | d_q[0]) ? d_q - a1_ext : d_q;
						c_n   = {p_sum[C-1], p_sum[C-1:1]};
						d_n   = {q_dif[C-1], q_dif[C-1:1]};
					end
				end
			end
			ST_CMP: begin
				if (u_q > v_q) begin
					u_n = u_q - v_q;
					if (odd_q) begin
						p_sum = (a_q < c_q) ? a_q + m_ext : a_q;
						a_n   = p_sum - c_q;
					end else begin
						a_n = a_q - c_q;
						b_n = b_q - d_q;
					end
				end else if (u_q < v_q) begin
					v_n = v_q - u_q;
					if (odd_q) begin
						p_sum = (c_q < a_q) ? c_q + m_ext : c_q;
						c_n   = p_sum - a_q;
					end else begin
						c_n = c_q - a_q;
						d_n = d_q - b_q;
					end
				end
			end
			ST_PICK: begin
				rem_n    = '0;
				bcnt_n   = '0;
				second_n = 1'b1;
				p_sum    = u_one ? a_q : c_q;
				neg_n    = p_sum[C-1];
				dd_n     = p_sum[C-1] ? '0 - p_sum : p_sum;
				if (!u_one && !v_one) begin
					status_n = STATUS_NOINV;
					res_n    = '0;
				end
			end
			ST_FIX: begin
				status_n = STATUS_OK;
				res_n    = (neg_q && rem_q != '0) ? m_q - rem_q : rem_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= STATUS_OK;
			u_q      <= '0;
			v_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			c_q      <= '0;
			d_q      <= '0;
			bcnt_q   <= '0;
			odd_q    <= 1'b0;
			neg_q    <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			status_q <= status_n;
			u_q      <= u_n;
			v_q      <= v_n;
			a_q      <= a_n;
			b_q      <= b_n;
			c_q      <= c_n;
			d_q      <= d_n;
			bcnt_q   <= bcnt_n;
			odd_q    <= odd_n;
			neg_q    <= neg_n;
			second_q <= second_n;
		end
	end

	always_ff @(posedge clk) begin
		m_q   <= m_n;
		a1_q  <= a1_n;
		rem_q <= rem_n;
		res_q <= res_n;
		dd_q  <= dd_n;
	end

	// outputs
	always_comb begin
		ctl.busy   = (state_q != ST_IDLE);
		ctl.done   = (state_q == ST_DONE);
		ctl.status = status_q;
		result     = res_q;
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("start while engine busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && status_q != STATUS_OK) |-> res_q == '0)
		else $error("error result not cleared");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REDUCE |-> rem_q < m_q)
		else $error("remainder not below modulus");

	a_odd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(odd_q && state_q == ST_TEST) |-> (a_q <= m_ext && c_q <= m_ext))
		else $error("odd path coefficient out of range");

endmodule

@@ sv/binary_modular_inverse.sv @@
// binary modular inverse: operand word store, inversion engine and result serializer
// depends on bmi_pkg and bmi_core
// the engine runs a reduce pass, the euclid steps and a second reduce pass, or ends early
// on a zero operand or no inverse; then one result word per cycle while out_stall is low
// throughput: one operand at a time, input stalled from the last word until all
// result words are taken; reset clears control, the word stores are unknown until written

module binary_modular_inverse import bmi_pkg::*; #(
	parameter int WORDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  word_index,
	input  logic [31:0] value_word,
	input  logic [31:0] modulus_word,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_index,
	output logic [31:0] result_word,
	output logic [1:0]  status,
	output logic        out_last
);

	localparam int W  = 32 * WORDS;
	localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LW = $clog2(WORDS + 1);

	logic [31:0]   value_store_q [WORDS];
	logic [31:0]   modulus_store_q [WORDS];
	logic [LW-1:0] len_q;
	logic          start_q, out_valid_q;
	logic [IW-1:0] cnt_q;
	logic [W-1:0]  res_q, ax, nx, core_res;
	logic [1:0]    status_q;
	bmi_ctl_t      core_ctl;
	logic          in_acc, out_acc, in_range, last_word;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign in_range  = (32'(word_index) < WORDS);
	assign in_stall  = start_q || core_ctl.busy || out_valid_q;
	assign last_word = ((LW'(cnt_q) + LW'(1)) == len_q);

	always_ff @(posedge clk) begin
		if (in_acc && in_range) begin
			value_store_q[IW'(word_index)]   <= value_word;
			modulus_store_q[IW'(word_index)] <= modulus_word;
		end
	end

	// words at or above the operand length read as zero
	for (genvar i = 0; i < WORDS; i++) begin : g_mask
		assign ax[i*32 +: 32] = (LW'(i) < len_q) ? value_store_q[i] : 32'd0;
		assign nx[i*32 +: 32] = (LW'(i) < len_q) ? modulus_store_q[i] : 32'd0;
	end

	bmi_core #(.WORDS(WORDS)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start_q),
		.value_in   (ax),
		.modulus_in (nx),
		.ctl        (core_ctl),
		.result     (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			status_q    <= STATUS_OK;
		end else begin
			start_q <= in_acc && last;
			if (in_acc && last)
				len_q <= in_range ? LW'(word_index) + LW'(1) : LW'(WORDS);
			if (core_ctl.done) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				status_q    <= core_ctl.status;
			end else if (out_acc) begin
				if (last_word)
					out_valid_q <= 1'b0;
				else
					cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	// result words leave least significant first
	always_ff @(posedge clk) begin
		if (core_ctl.done)
			res_q <= core_res;
		else if (out_acc)
			res_q <= res_q >> 32;
	end

	assign out_valid   = out_valid_q;
	assign out_index   = 3'(cnt_q);
	assign result_word = (status_q == STATUS_OK) ? res_q[31:0] : 32'd0;
	assign status      = status_q;
	assign out_last    = last_word;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !core_ctl.busy && !start_q)
		else $error("result transaction overlaps engine run");

endmodule
